// ----- hw/rtl/scba_pkg.sv -----
// types, codes and fixed widths for the size class block allocator
// no dependencies; every other file imports this package
package scba_pkg;

	localparam int ADDR_W = 13;
	localparam int SIZE_W = 16;

	localparam logic [1:0] REQ_ALLOC  = 2'd0;
	localparam logic [1:0] REQ_FREE   = 2'd1;
	localparam logic [1:0] REQ_RESIZE = 2'd2;
	localparam logic [1:0] REQ_BAD    = 2'd3;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_LARGE   = 2'd1;
	localparam logic [1:0] STS_OOM     = 2'd2;
	localparam logic [1:0] STS_INVALID = 2'd3;

	localparam logic [1:0] SRC_ZERO  = 2'd0;
	localparam logic [1:0] SRC_TOP   = 2'd1;
	localparam logic [1:0] SRC_CARVE = 2'd2;
	localparam logic [1:0] SRC_BADDR = 2'd3;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [SIZE_W-1:0] req_size;
		logic [SIZE_W-1:0] old_size;
		logic [ADDR_W-1:0] block_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] slot_addr;
		logic [1:0]        status;
		logic              copy_needed;
	} rsp_t;

	typedef struct packed {
		logic       capture;
		logic       sel_old;
		logic       pop_read;
		logic       pop_write;
		logic       carve;
		logic       free;
		logic       set_res;
		logic [1:0] res_status;
		logic [1:0] res_src;
		logic       set_copy;
		logic       load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic       invalid;
		logic [1:0] req_type;
		logic       nlarge;
		logic       olarge;
		logic       same_class;
		logic       top_valid;
		logic       carve_ok;
		logic       out_busy;
	} dp_stat_t;

endpackage

// ----- hw/rtl/scba_ctrl.sv -----
// controller state machine for the size class block allocator
// depends on scba_pkg; drives the datapath through ctl_cmd_t
module scba_ctrl import scba_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_EXEC     = 3'd1;
	localparam logic [2:0] S_POP      = 3'd2;
	localparam logic [2:0] S_FREE_OLD = 3'd3;
	localparam logic [2:0] S_FINISH   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] after_alloc;
	logic       is_resize;

	assign req_ready = (state_q == S_IDLE);
	assign is_resize = (stat.req_type == REQ_RESIZE);
	assign after_alloc = (is_resize && !stat.olarge) ? S_FREE_OLD : S_FINISH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.res_status = STS_OK;
		cmd.res_src = SRC_ZERO;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.set_res = 1'b1;
				state_d = S_FINISH;
				if (stat.invalid) begin
					cmd.res_status = STS_INVALID;
				end else if (stat.req_type == REQ_FREE) begin
					if (stat.nlarge) begin
						cmd.res_status = STS_LARGE;
					end else begin
						cmd.free = 1'b1;
					end
				end else if (is_resize && stat.nlarge && stat.olarge) begin
					cmd.res_status = STS_LARGE;
				end else if (is_resize && stat.same_class) begin
					cmd.res_src = SRC_BADDR;
				end else if (stat.nlarge) begin
					cmd.res_status = STS_LARGE;
					cmd.set_copy = is_resize;
					state_d = after_alloc;
				end else if (stat.top_valid) begin
					cmd.res_src = SRC_TOP;
					cmd.pop_read = 1'b1;
					state_d = S_POP;
				end else if (stat.carve_ok) begin
					cmd.res_src = SRC_CARVE;
					cmd.carve = 1'b1;
					cmd.set_copy = is_resize;
					state_d = after_alloc;
				end else begin
					cmd.res_status = STS_OOM;
				end
			end
			S_POP: begin
				cmd.pop_write = 1'b1;
				cmd.set_copy = is_resize;
				state_d = after_alloc;
			end
			S_FREE_OLD: begin
				cmd.sel_old = 1'b1;
				cmd.free = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/scba_dpath.sv -----
// datapath: size class decode, per-class list heads and carve counters,
// link memory, result and output registers; depends on scba_pkg
module scba_dpath import scba_pkg::*; #(
	parameter int UNIT_BYTES = 8,
	parameter int NUM_CLASSES = 16,
	parameter int SLOTS_PER_CLASS = 512
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  ctl_cmd_t cmd,
	output dp_stat_t stat,
	input  logic     rsp_ready,
	output logic     rsp_valid,
	output rsp_t     rsp
);

	localparam int SHIFT = SIZE_W + $clog2(UNIT_BYTES);
	localparam longint unsigned MULT_L =
		((64'd1 << SHIFT) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES);
	localparam logic [SIZE_W:0] MULT_C = (SIZE_W + 1)'(MULT_L);
	localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int CNT_W = $clog2(SLOTS_PER_CLASS + 1);
	localparam longint unsigned TOTAL_L = 64'(NUM_CLASSES) * 64'(SLOTS_PER_CLASS);
	localparam longint unsigned LINK_DEPTH = (TOTAL_L < (64'd1 << ADDR_W)) ?
		TOTAL_L : (64'd1 << ADDR_W);
	localparam int LINK_AW = $clog2(LINK_DEPTH);

	logic [1:0]        type_q;
	logic [ADDR_W-1:0] baddr_q;
	logic              invalid_q;
	logic [CLS_W-1:0]  nc_q;
	logic [CLS_W-1:0]  oc_q;
	logic              nlarge_q;
	logic              olarge_q;
	logic              same_q;

	logic [LINK_AW-1:0] top_q [NUM_CLASSES];
	logic               top_vld_q [NUM_CLASSES];
	logic [CNT_W-1:0]   cnt_q [NUM_CLASSES];
	logic [LINK_AW:0]   link_mem [LINK_DEPTH];
	logic [LINK_AW:0]   link_rd_q;

	logic [ADDR_W-1:0] res_slot_q;
	logic [1:0]        res_status_q;
	logic              res_copy_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [2*SIZE_W+15:0] nprod;
	logic [2*SIZE_W+15:0] oprod;
	logic [SIZE_W-1:0]    nq;
	logic [SIZE_W-1:0]    oq;
	logic                 in_invalid;
	logic [CLS_W-1:0]     cls_sel;
	logic [31:0]          carve_full;
	logic                 in_range;
	logic [LINK_AW-1:0]   baddr_idx;
	logic [ADDR_W-1:0]    res_slot_d;

	// reciprocal multiply, exact for every 16-bit numerator
	always_comb begin
		nprod = (2*SIZE_W+16)'(req.req_size - 16'd1) * (2*SIZE_W+16)'(MULT_C);
		oprod = (2*SIZE_W+16)'(req.old_size - 16'd1) * (2*SIZE_W+16)'(MULT_C);
		nq = nprod[SHIFT +: SIZE_W];
		oq = oprod[SHIFT +: SIZE_W];
		in_invalid = (req.req_type == REQ_BAD) || (req.req_size == '0) ||
			((req.req_type == REQ_RESIZE) && (req.old_size == '0));
	end

	assign cls_sel = cmd.sel_old ? oc_q : nc_q;
	assign carve_full = 32'(cls_sel) * 32'(SLOTS_PER_CLASS) + 32'(cnt_q[cls_sel]);
	assign in_range = (64'(baddr_q) < TOTAL_L);
	assign baddr_idx = baddr_q[LINK_AW-1:0];

	always_comb begin
		case (cmd.res_src)
			SRC_TOP:   res_slot_d = ADDR_W'(top_q[cls_sel]);
			SRC_CARVE: res_slot_d = carve_full[ADDR_W-1:0];
			SRC_BADDR: res_slot_d = baddr_q;
			default:   res_slot_d = '0;
		endcase
	end

	always_comb begin
		stat.invalid = invalid_q;
		stat.req_type = type_q;
		stat.nlarge = nlarge_q;
		stat.olarge = olarge_q;
		stat.same_class = same_q;
		stat.top_valid = top_vld_q[cls_sel];
		stat.carve_ok = (32'(cnt_q[cls_sel]) < 32'(SLOTS_PER_CLASS));
		stat.out_busy = rsp_valid_q && !rsp_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q <= req.req_type;
			baddr_q <= req.block_addr;
			invalid_q <= in_invalid;
			nc_q <= nq[CLS_W-1:0];
			oc_q <= oq[CLS_W-1:0];
			nlarge_q <= (32'(nq) >= 32'(NUM_CLASSES));
			olarge_q <= (32'(oq) >= 32'(NUM_CLASSES));
			same_q <= (nq == oq);
		end
		if (cmd.pop_read) begin
			link_rd_q <= link_mem[top_q[cls_sel]];
		end
		if (cmd.free && in_range) begin
			link_mem[baddr_idx] <= {top_vld_q[cls_sel], top_q[cls_sel]};
			top_q[cls_sel] <= baddr_idx;
		end else if (cmd.pop_write) begin
			top_q[cls_sel] <= link_rd_q[LINK_AW-1:0];
		end
		if (cmd.set_res) begin
			res_slot_q <= res_slot_d;
			res_status_q <= cmd.res_status;
		end
		if (cmd.capture) begin
			res_copy_q <= 1'b0;
		end else if (cmd.set_copy) begin
			res_copy_q <= 1'b1;
		end
		if (cmd.load_out) begin
			rsp_q.slot_addr <= res_slot_q;
			rsp_q.status <= res_status_q;
			rsp_q.copy_needed <= res_copy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				top_vld_q[i] <= 1'b0;
				cnt_q[i] <= '0;
			end
		end else begin
			if (cmd.free && in_range) begin
				top_vld_q[cls_sel] <= 1'b1;
			end else if (cmd.pop_write) begin
				top_vld_q[cls_sel] <= link_rd_q[LINK_AW];
			end
			if (cmd.carve) begin
				cnt_q[cls_sel] <= cnt_q[cls_sel] + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// ----- hw/rtl/size_class_block_allocator_unit.sv -----
// Size class block allocator, top level.
// Requests (allocate, free, resize) arrive on the req channel as one req_t
// transfer each; every request gives exactly one rsp_t transfer on the rsp
// channel, in order, carrying slot address, status and the copy flag.
// Both channels are valid/ready; a transfer happens when valid and ready are
// both high at a rising edge of clk.
// One request is worked on at a time. Free, large, invalid, out of memory and
// same-class resize requests go from capture through execute to the finish
// state; an allocation that pops a free list adds a pop state (registered read
// of the link memory), and a resize that also frees its old slot adds another.
// The result sits in an output register; the next request is taken while it
// waits, and only the final write into that register holds off while the
// receiver stalls.
// Reset (arst_n low) empties every free list and zeroes every carve counter;
// the link memory needs no clearing and the block is ready right after reset.
// Depends on scba_pkg, scba_ctrl and scba_dpath.
module size_class_block_allocator_unit import scba_pkg::*; #(
	parameter int UNIT_BYTES = 8,
	parameter int NUM_CLASSES = 16,
	parameter int SLOTS_PER_CLASS = 512
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	scba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	scba_dpath #(
		.UNIT_BYTES      (UNIT_BYTES),
		.NUM_CLASSES     (NUM_CLASSES),
		.SLOTS_PER_CLASS (SLOTS_PER_CLASS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
